// File: rtl/core/cbd_pkg.sv
// shared types, constants and decode functions of the cpu bus decoder
`default_nettype none

package cbd_pkg;

  // work ram size, mirrored below the ppu window; must be a power of two
  localparam int RAM_BYTES = 2048;
  localparam int RAM_AW    = $clog2(RAM_BYTES);

  localparam int S_DATA_W = 48;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 56;
  localparam int M_USER_W = 3;

  localparam logic [15:0] ADDR_PPU      = 16'h2000;
  localparam logic [15:0] ADDR_APU      = 16'h4000;
  localparam logic [15:0] ADDR_APU_LAST = 16'h4013;
  localparam logic [15:0] ADDR_DMA      = 16'h4014;
  localparam logic [15:0] ADDR_APU_STAT = 16'h4015;
  localparam logic [15:0] ADDR_PAD_ONE  = 16'h4016;
  localparam logic [15:0] ADDR_PAD_TWO  = 16'h4017;
  localparam logic [15:0] ADDR_CART     = 16'h4020;

  localparam logic [2:0] PH_EVEN = 3'd0;
  localparam logic [2:0] PH_ODD  = 3'd3;
  localparam logic [2:0] PH_LAST = 3'd5;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_RAM  = 3'd1,
    TGT_PPU  = 3'd2,
    TGT_APU  = 3'd3,
    TGT_PAD  = 3'd4,
    TGT_DMA  = 3'd5,
    TGT_CART = 3'd6
  } target_t;

  typedef struct packed {
    logic [7:0]  ext_read_data;
    logic [7:0]  pad_two;
    logic [7:0]  pad_one;
    logic [7:0]  write_data;
    logic [15:0] address;
    logic [1:0]  action;
  } cbd_item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [15:0] ext_address;
    logic        ext_write;
    logic [7:0]  ext_data;
    logic [7:0]  read_data;
    logic        write_ok;
    logic        cpu_step;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        dma_active;
  } cbd_result_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } cbd_ram_wr_t;

  function automatic target_t read_target(input logic [15:0] a);
    target_t t;
    if (a < ADDR_PPU)                               t = TGT_RAM;
    else if (a < ADDR_APU)                          t = TGT_PPU;
    else if (a <= ADDR_APU_LAST || a == ADDR_APU_STAT) t = TGT_APU;
    else if (a == ADDR_DMA)                         t = TGT_DMA;
    else if (a == ADDR_PAD_ONE || a == ADDR_PAD_TWO) t = TGT_PAD;
    else if (a >= ADDR_CART)                        t = TGT_CART;
    else                                            t = TGT_NONE;
    return t;
  endfunction

  // writes differ from reads only at the second pad port, which goes to the apu
  function automatic target_t write_target(input logic [15:0] a);
    target_t t;
    if (a == ADDR_PAD_TWO) t = TGT_APU;
    else if (a == ADDR_PAD_ONE) t = TGT_PAD;
    else t = read_target(a);
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cbd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module cbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cbd_engine.sv
// bus decode, controller shifters, clock phase and sprite dma state
`default_nettype none

module cbd_engine (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  go,
  input  wire cbd_pkg::cbd_item_t    item,
  input  wire logic [7:0]            ram_rdata,
  output      cbd_pkg::cbd_result_t  res,
  output      cbd_pkg::cbd_ram_wr_t  ram_wr,
  output      logic [7:0]            page_next,
  output      logic [7:0]            index_next
);

  import cbd_pkg::*;

  typedef struct packed {
    logic [7:0] pad_one;
    logic [7:0] pad_two;
    logic [7:0] page;
    logic [7:0] index;
    logic [7:0] latch;
    logic       busy;
    logic       sync;
    logic       pending;
    logic [2:0] phase;
  } dma_state_t;

  dma_state_t  st;
  dma_state_t  st_next;
  logic [2:0]  ph;
  logic        rd_en;
  logic        dma_rd;
  logic [15:0] rd_a;
  target_t     rd_tgt;
  target_t     wr_tgt;
  logic [7:0]  rd_byte;
  logic        fwd;

  // ticks only read the bus for the dma, at page and index
  assign rd_a   = (item.action == ACT_TICK) ? {st.page, st.index} : item.address;
  assign rd_tgt = read_target(rd_a);
  assign wr_tgt = write_target(item.address);
  assign ph     = (st.phase > PH_LAST) ? PH_EVEN : st.phase;

  always_comb begin
    st_next      = st;
    res          = '0;
    ram_wr       = '0;
    rd_en        = 1'b0;
    dma_rd       = 1'b0;
    rd_byte      = '0;
    fwd          = 1'b0;
    st_next.pending = 1'b0;
    if (st.pending) begin
      st_next.latch = item.ext_read_data;
    end

    case (item.action)
      ACT_READ: begin
        rd_en = 1'b1;
      end
      ACT_WRITE: begin
        res.target = wr_tgt;
        case (wr_tgt)
          TGT_RAM: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = item.address[RAM_AW-1:0];
            ram_wr.data = item.write_data;
            res.write_ok = 1'b1;
          end
          TGT_DMA: begin
            st_next.page  = item.write_data;
            st_next.index = '0;
            st_next.busy  = 1'b1;
          end
          TGT_PAD: begin
            st_next.pad_one = item.pad_one;
            st_next.pad_two = item.pad_two;
            res.write_ok    = 1'b1;
          end
          TGT_PPU, TGT_APU, TGT_CART: begin
            res.ext_address = item.address;
            res.ext_write   = 1'b1;
            res.ext_data    = item.write_data;
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        st_next.phase = (ph == PH_LAST) ? PH_EVEN : ph + 3'd1;
        if (ph == PH_EVEN || ph == PH_ODD) begin
          if (st.busy) begin
            if (st.sync) begin
              if (ph == PH_ODD) begin
                st_next.sync = 1'b0;
              end
            end else if (ph == PH_EVEN) begin
              dma_rd = 1'b1;
              rd_en  = 1'b1;
            end else begin
              res.oam_write = 1'b1;
              res.oam_index = st.index;
              res.oam_data  = st_next.latch;
              st_next.index = st.index + 8'd1;
              if (st.index == 8'hFF) begin
                st_next.busy = 1'b0;
                st_next.sync = 1'b1;
              end
            end
          end else begin
            res.cpu_step = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (rd_en) begin
      res.target = rd_tgt;
      case (rd_tgt)
        TGT_RAM: begin
          rd_byte = ram_rdata;
        end
        TGT_PAD: begin
          if (rd_a == ADDR_PAD_ONE) begin
            rd_byte         = {7'd0, st.pad_one[0]};
            st_next.pad_one = {1'b0, st.pad_one[7:1]};
          end else begin
            rd_byte         = {7'd0, st.pad_two[0]};
            st_next.pad_two = {1'b0, st.pad_two[7:1]};
          end
        end
        TGT_PPU, TGT_APU, TGT_CART: begin
          res.ext_address = rd_a;
          fwd             = 1'b1;
        end
        default: ;
      endcase
      res.read_data = rd_byte;
      if (dma_rd) begin
        // forwarded bytes arrive with the next request
        if (fwd) begin
          st_next.pending = 1'b1;
        end else begin
          st_next.latch = rd_byte;
        end
      end
    end

    res.dma_active = st_next.busy;
  end

  assign page_next  = go ? st_next.page : st.page;
  assign index_next = go ? st_next.index : st.index;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{pad_one: 8'd0, pad_two: 8'd0, page: 8'd0, index: 8'd0, latch: 8'd0,
              busy: 1'b0, sync: 1'b1, pending: 1'b0, phase: 3'd0};
    end else if (go) begin
      st <= st_next;
    end
  end

  a_oam_only_busy: assert property (@(posedge clk) disable iff (rst)
    (go && res.oam_write) |-> st.busy)
    else $error("sprite write without a running dma");

  a_step_not_busy: assert property (@(posedge clk) disable iff (rst)
    (go && res.cpu_step) |-> !st.busy)
    else $error("cpu stepped during dma");

  a_dma_done_clears: assert property (@(posedge clk) disable iff (rst)
    (go && res.oam_write && res.oam_index == 8'hFF && item.action == ACT_TICK)
      |=> (!st.busy && st.sync))
    else $error("dma did not finish after the last sprite byte");

endmodule

`default_nettype wire

// File: rtl/core/cpu_bus_decode_sprite_dma_top.sv
// Top level of the cpu bus decoder with sprite dma. Each request (read, write
// or master tick) is taken into an input register while the work ram is read
// at its address, decoded from that register and placed in the result register,
// which offers it on the output: one request per cycle while the output is not stalled.
// The single read port of the work ram, addressed as the request is accepted,
// sets that rate; a ram write from the request ahead is forwarded to it. After
// reset a clearing pass zeroes the work ram, one byte per cycle over all 2048
// bytes, and no request is accepted until it ends.
`default_nettype none

module cpu_bus_decode_sprite_dma_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // address[15:0], write_data[23:16], pad_one[31:24], pad_two[39:32],
  // ext_read_data[47:40]
  input  wire logic [cbd_pkg::S_DATA_W-1:0]  s_tdata,
  // action[1:0]
  input  wire logic [cbd_pkg::S_USER_W-1:0]  s_tuser,
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // ext_address[15:0], ext_write[16], ext_data[24:17], read_data[32:25],
  // write_ok[33], cpu_step[34], oam_write[35], oam_index[43:36],
  // oam_data[51:44], dma_active[52], zero[55:53]
  output      logic [cbd_pkg::M_DATA_W-1:0]  m_tdata,
  // target[2:0]
  output      logic [cbd_pkg::M_USER_W-1:0]  m_tuser
);

  import cbd_pkg::*;

  logic              clearing;
  logic [RAM_AW-1:0] clr_cnt;
  logic              v1;
  cbd_item_t         item;
  logic              adv;
  logic              accept;
  cbd_result_t       res;
  cbd_ram_wr_t       eng_wr;
  cbd_ram_wr_t       ram_wr;
  logic [7:0]        page_next;
  logic [7:0]        index_next;
  logic [15:0]       rd_addr;
  logic [RAM_AW-1:0] rd_idx;
  logic [7:0]        ram_q;
  logic              byp;
  logic [7:0]        byp_data;
  logic [7:0]        ram_rdata;

  assign adv      = v1 && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!v1 || adv);
  assign accept   = s_tvalid && s_tready;

  // dma reads use the page and index as they stand after the request ahead
  assign rd_addr  = (s_tuser == ACT_TICK) ? {page_next, index_next} : s_tdata[15:0];
  assign rd_idx   = rd_addr[RAM_AW-1:0];

  always_comb begin
    ram_wr = eng_wr;
    ram_wr.en = eng_wr.en && adv;
    if (clearing) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_cnt;
      ram_wr.data = '0;
    end
  end

  cbd_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_work_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  assign ram_rdata = byp ? byp_data : ram_q;

  cbd_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .go         (adv),
    .item       (item),
    .ram_rdata  (ram_rdata),
    .res        (res),
    .ram_wr     (eng_wr),
    .page_next  (page_next),
    .index_next (index_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + RAM_AW'(1);
      if (clr_cnt == RAM_AW'(RAM_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (adv) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= {s_tdata, s_tuser};
      byp      <= ram_wr.en && (ram_wr.addr == rd_idx);
      byp_data <= ram_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= res.target;
      m_tdata <= {3'd0, res.dma_active, res.oam_data, res.oam_index, res.oam_write,
                  res.cpu_step, res.write_ok, res.read_data, res.ext_data,
                  res.ext_write, res.ext_address};
    end
  end

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("request accepted during ram clearing");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && m_tvalid && !m_tready) |=> v1)
    else $error("input stage dropped a request while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("advanced request produced no result");

endmodule

`default_nettype wire
